// ===== hw/rtl/lsam_pkg.sv =====
// shared types and codes for the limit switch arm motor controller
package lsam_pkg;

  // arm modes
  localparam logic [2:0] MODE_STOPPED = 3'd0;
  localparam logic [2:0] MODE_MOVIN   = 3'd1;
  localparam logic [2:0] MODE_MOVOUT  = 3'd2;
  localparam logic [2:0] MODE_CLOSED  = 3'd3;
  localparam logic [2:0] MODE_OPEN    = 3'd4;
  localparam logic [2:0] MODE_ERROR   = 3'd5;

  // serial command codes
  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_IN   = 2'd1;
  localparam logic [1:0] CMD_OUT  = 2'd2;
  localparam logic [1:0] CMD_STOP = 2'd3;

  // drive bit positions
  localparam int DRV_RIN  = 0;
  localparam int DRV_ROUT = 1;
  localparam int DRV_LIN  = 2;
  localparam int DRV_LOUT = 3;

  // configuration register indexes and reset values
  localparam int          ADDR_W       = 4;
  localparam logic [1:0]  REG_DEBOUNCE = 2'd0;
  localparam logic [1:0]  REG_EXTEND   = 2'd1;
  localparam logic [1:0]  REG_BLINK    = 2'd2;
  localparam logic [15:0] DEBOUNCE_RST = 16'd1000;
  localparam logic [15:0] EXTEND_RST   = 16'd1000;
  localparam logic [15:0] BLINK_RST    = 16'd200;

  typedef struct packed {
    logic       in_sensor;
    logic       out_sensor;
    logic       out_button;
    logic       in_button;
    logic [1:0] func;
  } tick_t;

  typedef struct packed {
    logic [15:0] debounce_ticks;
    logic [15:0] extend_ticks;
    logic [15:0] blink_ticks;
  } cfg_t;

endpackage

// ===== hw/rtl/lsam_if.sv =====
// stream interfaces for tick items and result items
interface lsam_tick_if;
  logic       valid;
  logic       ready;
  logic       in_sensor;
  logic       out_sensor;
  logic       out_button;
  logic       in_button;
  logic [1:0] func;

  modport source (output valid, in_sensor, out_sensor, out_button, in_button, func,
                  input ready);
  modport sink   (input valid, in_sensor, out_sensor, out_button, in_button, func,
                  output ready);
endinterface

interface lsam_result_if;
  logic       valid;
  logic       ready;
  logic       relay_in_on;
  logic       relay_out_on;
  logic       led_in_on;
  logic       led_out_on;
  logic [2:0] arm_mode;

  modport source (output valid, relay_in_on, relay_out_on, led_in_on, led_out_on,
                  arm_mode, input ready);
  modport sink   (input valid, relay_in_on, relay_out_on, led_in_on, led_out_on,
                  arm_mode, output ready);
endinterface

// ===== hw/rtl/limit_switch_arm_motor_fsm.sv =====
// top level: input register, per-tick core, result register, apb registers
// tick captured in the input register, then core state and result valid registered on a step
// throughput: one tick per cycle while the result is taken, set by the state update in the core
// the input register is held while the result register waits to be taken
// reset (synchronous, rst high): mode stopped, timers and drives cleared,
// registers back to debounce 1000, extend 1000, blink 200
module limit_switch_arm_motor_fsm (
  input  logic                        clk,
  input  logic                        rst,
  lsam_tick_if.sink                   tick,
  lsam_result_if.source               result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lsam_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import lsam_pkg::*;

  cfg_t       cfg;
  tick_t      item;
  logic       item_valid;
  logic       step;
  logic       res_valid;
  logic [3:0] drive;
  logic [2:0] mode;

  lsam_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  // handshake: core steps when the result register is free or being taken
  assign step       = item_valid && (!res_valid || result.ready);
  assign tick.ready = !rst && (!item_valid || step);

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (tick.ready) begin
      item_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      item.in_sensor  <= tick.in_sensor;
      item.out_sensor <= tick.out_sensor;
      item.out_button <= tick.out_button;
      item.in_button  <= tick.in_button;
      item.func       <= tick.func;
    end
  end

  lsam_core u_core (
    .clk, .rst, .step, .tick(item), .cfg, .drive, .mode
  );

  // result valid flag; payload is the core state
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  assign result.valid        = res_valid;
  assign result.relay_in_on  = drive[DRV_RIN];
  assign result.relay_out_on = drive[DRV_ROUT];
  assign result.led_in_on    = drive[DRV_LIN];
  assign result.led_out_on   = drive[DRV_LOUT];
  assign result.arm_mode     = mode;
endmodule

// ===== hw/rtl/lsam_regs.sv =====
// apb configuration registers
module lsam_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lsam_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output lsam_pkg::cfg_t            cfg
);
  import lsam_pkg::*;

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks <= DEBOUNCE_RST;
      cfg.extend_ticks   <= EXTEND_RST;
      cfg.blink_ticks    <= BLINK_RST;
    end else if (wr) begin
      unique case (idx)
        REG_DEBOUNCE: cfg.debounce_ticks <= pwdata[15:0];
        REG_EXTEND:   cfg.extend_ticks   <= pwdata[15:0];
        REG_BLINK:    cfg.blink_ticks    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      REG_DEBOUNCE: prdata = {16'd0, cfg.debounce_ticks};
      REG_EXTEND:   prdata = {16'd0, cfg.extend_ticks};
      REG_BLINK:    prdata = {16'd0, cfg.blink_ticks};
      default:      prdata = 32'd0;
    endcase
  end
endmodule

// ===== hw/rtl/lsam_core.sv =====
// per-tick state machine, timers and drive logic; state doubles as result
module lsam_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  lsam_pkg::tick_t  tick,
  input  lsam_pkg::cfg_t   cfg,
  output logic [3:0]       drive,
  output logic [2:0]       mode
);
  import lsam_pkg::*;

  logic [1:0]  pending;
  logic [15:0] deb_cnt;
  logic [15:0] ext_cnt;
  logic [15:0] blink_cnt;
  logic        phase;

  logic [2:0]  mode_next;
  logic [1:0]  pending_next;
  logic [15:0] deb_cnt_next;
  logic [15:0] ext_cnt_next;
  logic [15:0] blink_cnt_next;
  logic        phase_next;
  logic [3:0]  drive_next;

  logic        deb_ok;
  logic        ext_done;
  logic        blink_fire;
  logic        sw_in;
  logic        sw_out;
  logic [2:0]  mode_eff;
  logic [1:0]  pend_cmd;

  assign deb_ok     = (deb_cnt == 16'd0);
  assign ext_done   = (ext_cnt == 16'd0);
  assign blink_fire = (blink_cnt == 16'd0);
  assign pend_cmd   = (tick.func != CMD_NONE) ? tick.func : pending;

  always_comb begin
    deb_cnt_next   = deb_ok ? deb_cnt : deb_cnt - 16'd1;
    ext_cnt_next   = ext_done ? ext_cnt : ext_cnt - 16'd1;
    blink_cnt_next = blink_fire ? blink_cnt : blink_cnt - 16'd1;
    pending_next   = pend_cmd;
    sw_in          = 1'b0;
    sw_out         = 1'b0;
    phase_next     = phase;
    drive_next     = drive;

    // command and button arbitration
    priority if (pend_cmd == CMD_OUT) begin
      pending_next = CMD_NONE;
      sw_out       = 1'b1;
    end else if (deb_ok && tick.out_button) begin
      deb_cnt_next = cfg.debounce_ticks;
      sw_out       = 1'b1;
    end else if (pend_cmd == CMD_IN) begin
      pending_next = CMD_NONE;
      sw_in        = 1'b1;
    end else if (deb_ok && tick.in_button) begin
      deb_cnt_next = cfg.debounce_ticks;
      sw_in        = 1'b1;
    end else begin
      pending_next = pend_cmd;
    end
    if (pending_next == CMD_STOP) pending_next = CMD_NONE;

    // both limits force error
    mode_eff  = (tick.in_sensor && tick.out_sensor) ? MODE_ERROR : mode;
    mode_next = mode_eff;

    unique case (mode_eff)
      MODE_STOPPED: begin
        drive_next = 4'b0000;
        priority if (tick.in_sensor && !tick.out_sensor) mode_next = MODE_CLOSED;
        else if (!tick.in_sensor && tick.out_sensor) mode_next = MODE_OPEN;
        else if (sw_in && !tick.in_sensor) mode_next = MODE_MOVIN;
        else if (sw_out && !tick.out_sensor) mode_next = MODE_MOVOUT;
        else mode_next = mode_eff;
      end
      MODE_MOVIN: begin
        drive_next = 4'b0000;
        drive_next[DRV_RIN] = 1'b1;
        drive_next[DRV_LIN] = 1'b1;
        priority if (tick.in_sensor) begin
          ext_cnt_next = cfg.extend_ticks;
          mode_next    = MODE_CLOSED;
        end else if (sw_in || sw_out) begin
          mode_next = MODE_STOPPED;
        end else begin
          mode_next = mode_eff;
        end
      end
      MODE_MOVOUT: begin
        drive_next = 4'b0000;
        drive_next[DRV_ROUT] = 1'b1;
        drive_next[DRV_LOUT] = 1'b1;
        if (tick.out_sensor) mode_next = MODE_OPEN;
        if (sw_in || sw_out) mode_next = MODE_STOPPED;
      end
      MODE_CLOSED: begin
        if (ext_done) begin
          drive_next[DRV_RIN]  = 1'b0;
          drive_next[DRV_ROUT] = 1'b0;
        end
        if (sw_out) mode_next = MODE_MOVOUT;
      end
      MODE_OPEN: begin
        drive_next[DRV_RIN]  = 1'b0;
        drive_next[DRV_ROUT] = 1'b0;
        if (sw_in) mode_next = MODE_MOVIN;
      end
      MODE_ERROR: begin
        drive_next[DRV_RIN]  = 1'b0;
        drive_next[DRV_ROUT] = 1'b0;
        priority if (tick.in_sensor && !tick.out_sensor) mode_next = MODE_CLOSED;
        else if (!tick.in_sensor && tick.out_sensor) mode_next = MODE_OPEN;
        else if (!tick.in_sensor && !tick.out_sensor) mode_next = MODE_STOPPED;
        else mode_next = mode_eff;
      end
      default: mode_next = MODE_STOPPED;
    endcase

    // blink phase and indicator leds
    if (blink_fire) begin
      blink_cnt_next = cfg.blink_ticks;
      phase_next     = !phase;
      if (mode_next == MODE_CLOSED) begin
        drive_next[DRV_LIN]  = phase_next;
        drive_next[DRV_LOUT] = 1'b0;
      end else if (mode_next == MODE_OPEN) begin
        drive_next[DRV_LIN]  = 1'b0;
        drive_next[DRV_LOUT] = phase_next;
      end else if (mode_next == MODE_ERROR) begin
        drive_next[DRV_LIN]  = phase_next;
        drive_next[DRV_LOUT] = phase_next;
      end
    end
  end

  // state update once per tick
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_STOPPED;
      pending   <= CMD_NONE;
      deb_cnt   <= 16'd0;
      ext_cnt   <= 16'd0;
      blink_cnt <= 16'd0;
      phase     <= 1'b0;
      drive     <= 4'b0000;
    end else if (step) begin
      mode      <= mode_next;
      pending   <= pending_next;
      deb_cnt   <= deb_cnt_next;
      ext_cnt   <= ext_cnt_next;
      blink_cnt <= blink_cnt_next;
      phase     <= phase_next;
      drive     <= drive_next;
    end
  end
endmodule

// ===== hw/rtl/lsam_chk.sv =====
// port-level checks for the arm motor controller and their bind
module lsam_chk (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic       relay_in_on,
  input logic       relay_out_on,
  input logic [2:0] arm_mode
);
  import lsam_pkg::*;

  // no result right after reset
  a_rst_clears: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // stalled result holds its mode
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(arm_mode))
    else $error("stalled result changed");

  // relays never drive both directions
  a_relay_excl: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(relay_in_on && relay_out_on))
    else $error("both relays on");

  // error mode has both relays off
  a_error_off: assert property (@(posedge clk) disable iff (rst)
    res_valid && arm_mode == MODE_ERROR |-> !relay_in_on && !relay_out_on)
    else $error("relay on in error mode");
endmodule

bind limit_switch_arm_motor_fsm lsam_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .relay_in_on  (result.relay_in_on),
  .relay_out_on (result.relay_out_on),
  .arm_mode     (result.arm_mode)
);
